// File: hdl/anbf_pkg.sv
package anbf_pkg;

   localparam int MAX_FRAGMENTS_DEFAULT = 32;
   localparam int POSITION_BITS_DEFAULT = 24;

   localparam int OFFSET_W = 24;
   localparam int LENGTH_W = 25;
   localparam int INDEX_W  = 5;
   localparam int BYTE_W   = 8;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
   // a code confirms once the byte this far past its first zero arrives
   localparam int CONFIRM_DISTANCE = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_SINGLE_FRAGMENT_MODE = 1'b0;

   typedef struct packed {
      logic [OFFSET_W-1:0] frag_offset;
      logic [LENGTH_W-1:0] frag_length;
      logic [INDEX_W-1:0]  frag_index;
      logic                no_start_code;
      logic                last_fragment;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

endpackage

// File: hdl/anbf_req_if.sv
interface anbf_req_if;
   import anbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);

endinterface

// File: hdl/anbf_rsp_if.sv
interface anbf_rsp_if;
   import anbf_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] frag_offset;
   logic [LENGTH_W-1:0] frag_length;
   logic [INDEX_W-1:0]  frag_index;
   logic                no_start_code;
   logic                last_fragment;

   modport source (output valid, output frag_offset, output frag_length,
                   output frag_index, output no_start_code, output last_fragment,
                   input ready);
   modport sink   (input valid, input frag_offset, input frag_length,
                   input frag_index, input no_start_code, input last_fragment,
                   output ready);

endinterface

// File: hdl/anbf_csr.sv
module anbf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [anbf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [anbf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [anbf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic                           single_fragment_mode
);
   import anbf_pkg::*;

   logic                   mode_ff;
   logic                   mode_in;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic                   write_hit;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign write_hit = psel && penable && pwrite && pready &&
                      (reg_index == REG_SINGLE_FRAGMENT_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (write_hit) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_SINGLE_FRAGMENT_MODE) begin
         prdata = CSR_DATA_W'(mode_ff);
      end
   end

   assign single_fragment_mode = mode_ff;

endmodule

// File: hdl/anbf_scan.sv
module anbf_scan #(
   parameter int MAX_FRAGMENTS = anbf_pkg::MAX_FRAGMENTS_DEFAULT,
   parameter int POSITION_BITS = anbf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_accept,
   input  logic [anbf_pkg::BYTE_W-1:0] data_byte,
   input  logic                       frame_end,
   input  logic                       single_fragment_mode,
   output anbf_pkg::push_type         push,
   output anbf_pkg::rsp_type          first_rsp,
   output anbf_pkg::rsp_type          second_rsp
);
   import anbf_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
   localparam int PB    = POSITION_BITS;

   logic [1:0]       zero_run_ff,      zero_run_in;
   logic [PB-1:0]    byte_position_ff, byte_position_in;
   logic [CNT_W-1:0] frag_count_ff,    frag_count_in;
   logic [PB-1:0]    open_offset_ff,   open_offset_in;
   logic [PB-1:0]    pend_start_ff,    pend_start_in;
   logic             pend_valid_ff,    pend_valid_in;
   logic [2:0]       pend_length_ff,   pend_length_in;

   logic             confirm;
   logic             emit_confirm;
   logic [CNT_W-1:0] count_c;
   logic [PB-1:0]    open_c;
   logic             pend_valid_c;
   logic             detect;
   logic [1:0]       back;
   logic [PB:0]      frame_size;
   logic [PB:0]      final_length;
   logic [PB-1:0]    confirm_length;
   rsp_type          confirm_rsp;
   rsp_type          final_rsp;

   always_comb begin
      confirm = pend_valid_ff &&
                ({1'b0, byte_position_ff} >=
                 ({1'b0, pend_start_ff} + (PB+1)'(CONFIRM_DISTANCE)));
      emit_confirm = confirm && (frag_count_ff != '0);
      count_c      = confirm ? frag_count_ff + CNT_W'(1) : frag_count_ff;
      open_c       = confirm ? pend_start_ff + PB'(pend_length_ff) : open_offset_ff;
      pend_valid_c = pend_valid_ff && !confirm;

      confirm_length = (pend_start_ff >= open_offset_ff) ?
                       pend_start_ff - open_offset_ff : '0;
      confirm_rsp.frag_offset   = OFFSET_W'(open_offset_ff);
      confirm_rsp.frag_length   = LENGTH_W'(confirm_length);
      confirm_rsp.frag_index    = INDEX_W'(frag_count_ff - CNT_W'(1));
      confirm_rsp.no_start_code = 1'b0;
      confirm_rsp.last_fragment = 1'b0;

      back   = (zero_run_ff == 2'd3) ? 2'd3 : 2'd2;
      detect = !single_fragment_mode && !pend_valid_c &&
               (count_c < CNT_W'(MAX_FRAGMENTS)) && (data_byte == START_BYTE) &&
               (zero_run_ff >= 2'd2) && (byte_position_ff >= PB'(back));

      frame_size   = {1'b0, byte_position_ff} + (PB+1)'(1);
      final_length = (frame_size >= {1'b0, open_c}) ?
                     frame_size - {1'b0, open_c} : '0;
      if (single_fragment_mode) begin
         final_rsp.frag_offset   = '0;
         final_rsp.frag_length   = LENGTH_W'(frame_size);
         final_rsp.frag_index    = '0;
         final_rsp.no_start_code = 1'b0;
      end else if (count_c == '0) begin
         final_rsp.frag_offset   = '0;
         final_rsp.frag_length   = '0;
         final_rsp.frag_index    = '0;
         final_rsp.no_start_code = 1'b1;
      end else begin
         final_rsp.frag_offset   = OFFSET_W'(open_c);
         final_rsp.frag_length   = LENGTH_W'(final_length);
         final_rsp.frag_index    = INDEX_W'(count_c - CNT_W'(1));
         final_rsp.no_start_code = 1'b0;
      end
      final_rsp.last_fragment = 1'b1;

      // closing fragment always goes ahead of the frame-end result
      if (emit_confirm) begin
         first_rsp   = confirm_rsp;
         second_rsp  = final_rsp;
         push.first  = item_accept;
         push.second = item_accept && frame_end;
      end else begin
         first_rsp   = final_rsp;
         second_rsp  = final_rsp;
         push.first  = item_accept && frame_end;
         push.second = 1'b0;
      end
   end

   always_comb begin
      zero_run_in      = zero_run_ff;
      byte_position_in = byte_position_ff;
      frag_count_in    = frag_count_ff;
      open_offset_in   = open_offset_ff;
      pend_start_in    = pend_start_ff;
      pend_valid_in    = pend_valid_ff;
      pend_length_in   = pend_length_ff;
      if (item_accept) begin
         if (frame_end) begin
            zero_run_in      = '0;
            byte_position_in = '0;
            frag_count_in    = '0;
            open_offset_in   = '0;
            pend_start_in    = '0;
            pend_valid_in    = 1'b0;
            pend_length_in   = '0;
         end else begin
            frag_count_in  = count_c;
            open_offset_in = open_c;
            pend_valid_in  = pend_valid_c;
            if (detect) begin
               pend_start_in  = byte_position_ff - PB'(back);
               pend_length_in = 3'(back) + 3'd1;
               pend_valid_in  = 1'b1;
            end
            if (data_byte == '0) begin
               if (zero_run_ff != 2'd3) begin
                  zero_run_in = zero_run_ff + 2'd1;
               end
            end else begin
               zero_run_in = '0;
            end
            if (byte_position_ff != '1) begin
               byte_position_in = byte_position_ff + PB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff      <= '0;
         byte_position_ff <= '0;
         frag_count_ff    <= '0;
         open_offset_ff   <= '0;
         pend_start_ff    <= '0;
         pend_valid_ff    <= 1'b0;
         pend_length_ff   <= '0;
      end else begin
         zero_run_ff      <= zero_run_in;
         byte_position_ff <= byte_position_in;
         frag_count_ff    <= frag_count_in;
         open_offset_ff   <= open_offset_in;
         pend_start_ff    <= pend_start_in;
         pend_valid_ff    <= pend_valid_in;
         pend_length_ff   <= pend_length_in;
      end
   end

endmodule

// File: hdl/anbf_queue.sv
module anbf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  anbf_pkg::push_type          push,
   input  anbf_pkg::rsp_type           first_rsp,
   input  anbf_pkg::rsp_type           second_rsp,
   input  logic                        pop,
   output anbf_pkg::rsp_type           head,
   output anbf_pkg::queue_status_type  status
);
   import anbf_pkg::*;

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0] level_ff,  level_in;
   logic [QUEUE_LVL_W-1:0] push_num;
   logic                   pop_ok;

   always_comb begin
      pop_ok    = pop && (level_ff != '0);
      push_num  = QUEUE_LVL_W'(push.first) + QUEUE_LVL_W'(push.second);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_num);
      rd_ptr_in = pop_ok ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + push_num - QUEUE_LVL_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= first_rsp;
      end
      if (push.second) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= second_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.level = level_ff;

endmodule

// File: hdl/annexb_nal_fragmenter.sv
// Annex B NAL splitter: takes one frame byte per item at up to one item per
// clock, finds 00 00 01 / 00 00 00 01 start codes and returns one offset and
// length item per NAL unit (or one whole-frame item in single-fragment mode,
// or a no_start_code item). An input item is decided in the cycle it is
// accepted and its results land in a four-entry result queue, so results can
// appear the cycle after the byte. A byte that closes a unit and also ends
// the frame yields two results, drained one per cycle while rsp.ready is
// high; input is held off only while the queue has fewer than two free
// entries. A unit is reported when the byte four places past the first zero
// of the next start code arrives, or at frame end.
module annexb_nal_fragmenter #(
   parameter int MAX_FRAGMENTS = anbf_pkg::MAX_FRAGMENTS_DEFAULT,
   parameter int POSITION_BITS = anbf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   anbf_req_if.sink                       req,
   anbf_rsp_if.source                     rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [anbf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [anbf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [anbf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import anbf_pkg::*;

   logic             single_fragment_mode;
   logic             item_accept;
   push_type         push;
   rsp_type          first_rsp;
   rsp_type          second_rsp;
   rsp_type          head;
   queue_status_type status;

   anbf_csr u_csr (
      .clock                (clock),
      .reset                (reset),
      .psel                 (csr_psel),
      .penable              (csr_penable),
      .pwrite               (csr_pwrite),
      .paddr                (csr_paddr),
      .pwdata               (csr_pwdata),
      .prdata               (csr_prdata),
      .pready               (csr_pready),
      .single_fragment_mode (single_fragment_mode)
   );

   assign req.ready   = (status.level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
   assign item_accept = req.valid && req.ready;

   anbf_scan #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock                (clock),
      .reset                (reset),
      .item_accept          (item_accept),
      .data_byte            (req.data_byte),
      .frame_end            (req.frame_end),
      .single_fragment_mode (single_fragment_mode),
      .push                 (push),
      .first_rsp            (first_rsp),
      .second_rsp           (second_rsp)
   );

   anbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_rsp  (first_rsp),
      .second_rsp (second_rsp),
      .pop        (rsp.ready),
      .head       (head),
      .status     (status)
   );

   assign rsp.valid         = (status.level != '0);
   assign rsp.frag_offset   = head.frag_offset;
   assign rsp.frag_length   = head.frag_length;
   assign rsp.frag_index    = head.frag_index;
   assign rsp.no_start_code = head.no_start_code;
   assign rsp.last_fragment = head.last_fragment;

`ifndef ASSERT_OFF
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_frame_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (item_accept && req.frame_end) |=> (status.level >= $past(status.level)))
      else $error("frame end item produced no result");

   a_no_code_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.no_start_code) |->
      (rsp.frag_offset == '0 && rsp.frag_length == '0 && rsp.frag_index == '0 &&
       rsp.last_fragment))
      else $error("no_start_code item with nonzero fields");
`endif

endmodule
